>>> hdl/kcv_pkg.sv
// kcv_pkg: shared types, codes and the update microprogram of the tracker
// no dependencies; used by kcv_ctrl, kcv_datapath and the top level

package kcv_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL2,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   // working registers of the datapath
   typedef enum logic [4:0] {
      R_DT, R_R, R_Q, R_Z, R_ONE,
      R_X0, R_X1, R_P00, R_P01, R_P10, R_P11,
      R_A, R_T, R_Q00, R_Q01,
      R_N00, R_N01, R_N10, R_N11,
      R_S, R_K0, R_K1, R_Y
   } reg_type;

   localparam int REG_COUNT = 23;
   localparam int UOP_COUNT = 31;
   localparam int PC_W      = 5;

   // register map of the control port
   localparam logic [1:0] CSR_TIME_STEP = 2'd0;
   localparam logic [1:0] CSR_MEAS_VAR  = 2'd1;
   localparam logic [1:0] CSR_PROC_VAR  = 2'd2;

   typedef struct packed {
      op_type  op;
      reg_type dst;
      reg_type src_a;
      reg_type src_b;
   } uop_type;

   typedef struct packed {
      logic    load;
      logic    issue;
      logic    wr;
      logic    out_load;
      op_type  op;
      reg_type dst;
      reg_type src_a;
      reg_type src_b;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   // predict, gain, correct, covariance update
   function automatic uop_type uop_at(input logic [PC_W-1:0] pc);
      uop_type u;
      unique case (pc)
         5'd0:  u = '{OP_MUL, R_A,   R_DT,  R_DT};
         5'd1:  u = '{OP_MUL, R_Q00, R_A,   R_Q};
         5'd2:  u = '{OP_MUL, R_Q01, R_DT,  R_Q};
         5'd3:  u = '{OP_MUL, R_T,   R_DT,  R_X1};
         5'd4:  u = '{OP_ADD, R_X0,  R_X0,  R_T};
         5'd5:  u = '{OP_MUL, R_T,   R_DT,  R_P11};
         5'd6:  u = '{OP_ADD, R_N01, R_P01, R_T};
         5'd7:  u = '{OP_ADD, R_N10, R_P10, R_T};
         5'd8:  u = '{OP_MUL, R_T,   R_DT,  R_P10};
         5'd9:  u = '{OP_ADD, R_N00, R_P00, R_T};
         5'd10: u = '{OP_MUL, R_T,   R_DT,  R_N01};
         5'd11: u = '{OP_ADD, R_N00, R_N00, R_T};
         5'd12: u = '{OP_ADD, R_N00, R_N00, R_Q00};
         5'd13: u = '{OP_ADD, R_N01, R_N01, R_Q01};
         5'd14: u = '{OP_ADD, R_N10, R_N10, R_Q01};
         5'd15: u = '{OP_ADD, R_N11, R_P11, R_Q};
         5'd16: u = '{OP_ADD, R_S,   R_N00, R_R};
         5'd17: u = '{OP_DIV, R_K0,  R_N00, R_S};
         5'd18: u = '{OP_DIV, R_K1,  R_N10, R_S};
         5'd19: u = '{OP_SUB, R_Y,   R_Z,   R_X0};
         5'd20: u = '{OP_MUL, R_T,   R_K0,  R_Y};
         5'd21: u = '{OP_ADD, R_X0,  R_X0,  R_T};
         5'd22: u = '{OP_MUL, R_T,   R_K1,  R_Y};
         5'd23: u = '{OP_ADD, R_X1,  R_X1,  R_T};
         5'd24: u = '{OP_SUB, R_T,   R_ONE, R_K0};
         5'd25: u = '{OP_MUL, R_P00, R_T,   R_N00};
         5'd26: u = '{OP_MUL, R_P01, R_T,   R_N01};
         5'd27: u = '{OP_MUL, R_A,   R_K1,  R_N00};
         5'd28: u = '{OP_SUB, R_P10, R_N10, R_A};
         5'd29: u = '{OP_MUL, R_A,   R_K1,  R_N01};
         5'd30: u = '{OP_SUB, R_P11, R_N11, R_A};
         default: u = '{OP_NOP, R_A, R_A, R_A};
      endcase
      return u;
   endfunction

endpackage

>>> hdl/kcv_ctrl.sv
// kcv_ctrl: sequencer that steps the update microprogram and runs the handshakes
// depends on kcv_pkg

module kcv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  kcv_pkg::status_type status,
   output kcv_pkg::cmd_type    cmd
);

   kcv_pkg::state_type             state_ff, state_in;
   logic [kcv_pkg::PC_W-1:0]       pc_ff, pc_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   kcv_pkg::uop_type               uop;
   logic                           last;
   logic                           advance;
   logic                           out_free;

   assign uop      = kcv_pkg::uop_at(pc_ff);
   assign last     = (pc_ff == kcv_pkg::PC_W'(kcv_pkg::UOP_COUNT - 1));
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kcv_pkg::ST_IDLE: begin
            if (req_valid) state_in = kcv_pkg::ST_EXEC;
         end
         kcv_pkg::ST_EXEC: begin
            if (uop.op == kcv_pkg::OP_MUL) state_in = kcv_pkg::ST_MUL2;
            else if (uop.op == kcv_pkg::OP_DIV) state_in = kcv_pkg::ST_DIV;
            else if (last) state_in = kcv_pkg::ST_DONE;
         end
         kcv_pkg::ST_MUL2: begin
            state_in = last ? kcv_pkg::ST_DONE : kcv_pkg::ST_EXEC;
         end
         kcv_pkg::ST_DIV: begin
            if (status.div_done) state_in = last ? kcv_pkg::ST_DONE : kcv_pkg::ST_EXEC;
         end
         kcv_pkg::ST_DONE: begin
            if (out_free) state_in = kcv_pkg::ST_IDLE;
         end
         default: state_in = kcv_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.op       = uop.op;
      cmd.dst      = uop.dst;
      cmd.src_a    = uop.src_a;
      cmd.src_b    = uop.src_b;
      advance      = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         kcv_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         kcv_pkg::ST_EXEC: begin
            cmd.issue = 1'b1;
            advance   = (uop.op != kcv_pkg::OP_MUL) && (uop.op != kcv_pkg::OP_DIV);
         end
         kcv_pkg::ST_MUL2: begin
            advance = 1'b1;
         end
         kcv_pkg::ST_DIV: begin
            advance = status.div_done;
         end
         kcv_pkg::ST_DONE: begin
            cmd.out_load = out_free;
         end
         default: advance = 1'b0;
      endcase
      cmd.wr = advance;
   end

   always_comb begin
      pc_in = pc_ff;
      if (cmd.load) pc_in = '0;
      else if (advance) pc_in = pc_ff + 1'b1;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kcv_pkg::ST_IDLE;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == kcv_pkg::ST_EXEC && pc_ff == '0))
      else $error("accepted word did not start the microprogram");
   a_div_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr && cmd.op == kcv_pkg::OP_DIV) |-> (state_ff == kcv_pkg::ST_DIV))
      else $error("quotient written outside divide wait");
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (rsp_valid && state_ff == kcv_pkg::ST_IDLE))
      else $error("result load did not raise rsp valid");
`endif

endmodule

>>> hdl/kcv_datapath.sv
// kcv_datapath: working registers, saturating adder, shared multiplier and
// bit-serial divider; depends on kcv_pkg

module kcv_datapath #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  kcv_pkg::cmd_type    cmd,
   output kcv_pkg::status_type status,
   input  logic [31:0]         measured_position,
   input  logic                select_velocity,
   input  logic [30:0]         time_step,
   input  logic [30:0]         measurement_variance,
   input  logic [30:0]         velocity_process_variance,
   output logic [31:0]         estimate,
   output logic                saturated
);

   localparam int W  = DATA_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int QW = W + F;
   localparam int MW = (2 * W + 1 > QW) ? 2 * W + 1 : QW;
   localparam int CW = $clog2(QW + 1);
   localparam longint VMAX_L = (longint'(1) <<< (W - 1)) - 1;
   localparam longint VMIN_L = -VMAX_L - 1;
   localparam longint X0_L   = ((longint'(8) <<< F) + 50) / 100;
   localparam longint P_L    = longint'(100) <<< F;
   localparam longint ONE_L  = longint'(1) <<< F;
   localparam logic [W-1:0] X0_RST  = W'((X0_L > VMAX_L) ? VMAX_L : X0_L);
   localparam logic [W-1:0] P_RST   = W'((P_L > VMAX_L) ? VMAX_L : P_L);
   localparam logic [W-1:0] ONE_VAL = W'((ONE_L > VMAX_L) ? VMAX_L : ONE_L);
   localparam logic         ONE_SAT = (ONE_L > VMAX_L);

   // clamp into the working range, msb of the result is the saturation mark
   function automatic logic [W:0] clamp_l(input longint v);
      if (v > VMAX_L) return {1'b1, W'(VMAX_L)};
      if (v < VMIN_L) return {1'b1, W'(VMIN_L)};
      return {1'b0, W'(v)};
   endfunction

   // signed value from sign and magnitude, saturated
   function automatic logic [W:0] from_mag(input logic neg, input logic [MW-1:0] m);
      logic [MW-1:0] lim;
      logic [MW-1:0] mm;
      logic          ovf;
      lim = neg ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
      ovf = (m > lim);
      mm  = ovf ? lim : m;
      return {ovf, neg ? (~mm[W-1:0] + W'(1)) : mm[W-1:0]};
   endfunction

   logic [W-1:0]  regs_ff [kcv_pkg::REG_COUNT];
   logic          flag_ff, flag_in;
   logic          sel_ff;
   logic [31:0]   est_ff;
   logic          sat_ff;

   logic [W-1:0]  opa, opb;
   logic [W-1:0]  ma, mb;
   logic [W:0]    sum;
   logic [W:0]    add_res;
   logic [2*W-1:0] prod_ff;
   logic           mneg_ff;
   logic [2*W:0]   rnd;
   logic [W:0]     mul_res;

   logic [QW-1:0]  num_ff, quo_ff;
   logic [W-1:0]   rem_ff, dvs_ff;
   logic [CW-1:0]  dcnt_ff;
   logic           dbusy_ff, dneg_ff, dz_ff;
   logic [W:0]     trial;
   logic           qbit;
   logic [W:0]     div_res;

   logic [W:0]     c_dt, c_r, c_q, c_z;
   logic [W:0]     wr_val;
   logic [63:0]    est_w;
   logic           est_sat;
   logic [31:0]    est_val;

   assign opa = regs_ff[cmd.src_a];
   assign opb = regs_ff[cmd.src_b];
   assign ma  = opa[W-1] ? (~opa + W'(1)) : opa;
   assign mb  = opb[W-1] ? (~opb + W'(1)) : opb;

   // saturating add and subtract
   always_comb begin
      if (cmd.op == kcv_pkg::OP_SUB) sum = {opa[W-1], opa} - {opb[W-1], opb};
      else sum = {opa[W-1], opa} + {opb[W-1], opb};
      if (sum[W] != sum[W-1]) add_res = {1'b1, sum[W], {(W - 1){~sum[W]}}};
      else add_res = {1'b0, sum[W-1:0]};
   end

   // multiplier, from the registered product: round half away from zero, then saturate
   assign rnd     = {1'b0, prod_ff} + ((2 * W + 1)'(1) << (F - 1));
   assign mul_res = from_mag(mneg_ff, MW'(rnd >> F));

   // restoring divider, one quotient bit per cycle
   assign trial   = {rem_ff, num_ff[QW-1]};
   assign qbit    = (trial >= {1'b0, dvs_ff});
   assign div_res = dz_ff ? {1'b1, {W{1'b0}}} : from_mag(dneg_ff, MW'(quo_ff));
   assign status.div_done = dbusy_ff && (dcnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (cmd.issue && cmd.op == kcv_pkg::OP_DIV) begin
         dbusy_ff <= 1'b1;
      end else if (status.div_done) begin
         dbusy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue && cmd.op == kcv_pkg::OP_DIV) begin
         num_ff  <= {ma, {F{1'b0}}};
         rem_ff  <= '0;
         quo_ff  <= '0;
         dvs_ff  <= mb;
         dneg_ff <= opa[W-1] ^ opb[W-1];
         dz_ff   <= (opb == '0);
         dcnt_ff <= CW'(QW);
      end else if (dbusy_ff && dcnt_ff != '0) begin
         rem_ff  <= qbit ? W'(trial - {1'b0, dvs_ff}) : trial[W-1:0];
         quo_ff  <= {quo_ff[QW-2:0], qbit};
         num_ff  <= {num_ff[QW-2:0], 1'b0};
         dcnt_ff <= dcnt_ff - 1'b1;
      end
      if (cmd.issue && cmd.op == kcv_pkg::OP_MUL) begin
         prod_ff <= ma * mb;
         mneg_ff <= opa[W-1] ^ opb[W-1];
      end
   end

   // operands taken from the ports at load
   assign c_dt = clamp_l(longint'({33'd0, time_step}));
   assign c_r  = clamp_l(longint'({33'd0, measurement_variance}));
   assign c_q  = clamp_l(longint'({33'd0, velocity_process_variance}));
   assign c_z  = clamp_l(longint'({{32{measured_position[31]}}, measured_position}));

   always_comb begin
      unique case (cmd.op)
         kcv_pkg::OP_ADD, kcv_pkg::OP_SUB: wr_val = add_res;
         kcv_pkg::OP_MUL:                  wr_val = mul_res;
         kcv_pkg::OP_DIV:                  wr_val = div_res;
         default:                          wr_val = '0;
      endcase
   end

   // selected estimate, clamped to the 32-bit result field
   always_comb begin
      est_w   = 64'(signed'(sel_ff ? regs_ff[kcv_pkg::R_X1] : regs_ff[kcv_pkg::R_X0]));
      est_sat = 1'b0;
      est_val = est_w[31:0];
      if ($signed(est_w) > 64'sd2147483647) begin
         est_sat = 1'b1;
         est_val = 32'h7FFF_FFFF;
      end else if ($signed(est_w) < -64'sd2147483648) begin
         est_sat = 1'b1;
         est_val = 32'h8000_0000;
      end
   end

   always_comb begin
      flag_in = flag_ff;
      if (cmd.load) flag_in = c_dt[W] | c_r[W] | c_q[W] | c_z[W] | ONE_SAT;
      else if (cmd.wr && cmd.op != kcv_pkg::OP_NOP) flag_in = flag_ff | wr_val[W];
   end

   always_ff @(posedge clock) begin
      flag_ff <= flag_in;
      if (cmd.load) begin
         regs_ff[kcv_pkg::R_DT]  <= c_dt[W-1:0];
         regs_ff[kcv_pkg::R_R]   <= c_r[W-1:0];
         regs_ff[kcv_pkg::R_Q]   <= c_q[W-1:0];
         regs_ff[kcv_pkg::R_Z]   <= c_z[W-1:0];
         regs_ff[kcv_pkg::R_ONE] <= ONE_VAL;
         sel_ff                  <= select_velocity;
      end
      if (cmd.wr && cmd.op != kcv_pkg::OP_NOP) regs_ff[cmd.dst] <= wr_val[W-1:0];
      if (cmd.out_load) begin
         est_ff <= est_val;
         sat_ff <= flag_ff | est_sat;
      end
      if (reset) begin
         regs_ff[kcv_pkg::R_X0]  <= X0_RST;
         regs_ff[kcv_pkg::R_X1]  <= '0;
         regs_ff[kcv_pkg::R_P00] <= P_RST;
         regs_ff[kcv_pkg::R_P01] <= '0;
         regs_ff[kcv_pkg::R_P10] <= '0;
         regs_ff[kcv_pkg::R_P11] <= P_RST;
      end
   end

   assign estimate  = est_ff;
   assign saturated = sat_ff;

endmodule

>>> hdl/kalman_cv_position_tracker_unit.sv
// kalman_cv_position_tracker_unit: two-state constant-velocity tracker, top level
// depends on kcv_pkg, kcv_ctrl and kcv_datapath
// one word at a time: a new word is accepted only once the previous update is done;
// the two bit-serial gain divides dominate the update, the rest is one shared
// multiplier and one adder; the next word is taken while the previous result
// still waits in the output register
// reset: synchronous, restores position 0.08, velocity 0, covariance diag(100,100)
// and the register defaults; no clearing pass

module kalman_cv_position_tracker_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 24
) (
   input  logic        clock,
   input  logic        reset,
   // measurement words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] measured_position
   input  logic [0:0]  req_tuser,   // [0] select_velocity
   // estimate words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] estimate
   output logic [0:0]  rsp_tuser,   // [0] saturated
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [30:0]         time_step_ff;
   logic [30:0]         meas_var_ff;
   logic [30:0]         proc_var_ff;
   logic                csr_wr;
   kcv_pkg::cmd_type    cmd;
   kcv_pkg::status_type status;

   // register writes, picked up by the datapath when the next word is accepted
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= 31'd16777;
         meas_var_ff  <= 31'd48989;
         proc_var_ff  <= 31'd16777;
      end else if (csr_wr) begin
         if (csr_paddr[3:2] == kcv_pkg::CSR_TIME_STEP) time_step_ff <= csr_pwdata[30:0];
         if (csr_paddr[3:2] == kcv_pkg::CSR_MEAS_VAR)  meas_var_ff  <= csr_pwdata[30:0];
         if (csr_paddr[3:2] == kcv_pkg::CSR_PROC_VAR)  proc_var_ff  <= csr_pwdata[30:0];
      end
   end

   // read back, unmapped addresses read zero
   always_comb begin
      unique case (csr_paddr[3:2])
         kcv_pkg::CSR_TIME_STEP: csr_prdata = {1'b0, time_step_ff};
         kcv_pkg::CSR_MEAS_VAR:  csr_prdata = {1'b0, meas_var_ff};
         kcv_pkg::CSR_PROC_VAR:  csr_prdata = {1'b0, proc_var_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // sequencer
   kcv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and filter state
   kcv_datapath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .status                    (status),
      .measured_position         (req_tdata),
      .select_velocity           (req_tuser[0]),
      .time_step                 (time_step_ff),
      .measurement_variance      (meas_var_ff),
      .velocity_process_variance (proc_var_ff),
      .estimate                  (rsp_tdata),
      .saturated                 (rsp_tuser[0])
   );

endmodule

>>> tb/kalman_cv_position_tracker_unit_tb.sv
// kalman_cv_position_tracker_unit_tb: self-checking bench for the constant-velocity tracker
// depends on kcv_pkg (register addresses) and kalman_cv_position_tracker_unit

module kalman_cv_position_tracker_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint VMAX = 64'sd2147483647;
   localparam longint VMIN = -64'sd2147483648;
   localparam int FRAC = 24;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;     // [31:0] measured_position
   logic [0:0]  req_tuser;     // [0] select_velocity
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;     // [31:0] estimate
   logic [0:0]  rsp_tuser;     // [0] saturated
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   kalman_cv_position_tracker_unit i_dut (.*);

   // predictor state: configuration, filter state and the per-step saturation flag
   longint unsigned dt_cfg, rvar_cfg, qvar_cfg;
   longint pos_est, vel_est;
   longint cov [4];
   bit     sat_seen;

   typedef struct {
      logic [31:0] estimate;
      logic        saturated;
   } estimate_word_type;

   estimate_word_type expected_estimates [$];
   bit     failed;
   int     rsp_idle_max;   // upper bound of the result-side stall draw

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("Some tests failed");
      $finish;
   end

   // ---------------- fixed-point predictor ----------------
   function automatic longint clamp_w(longint v);
      if (v > VMAX) begin
         sat_seen = 1'b1;
         return VMAX;
      end
      if (v < VMIN) begin
         sat_seen = 1'b1;
         return VMIN;
      end
      return v;
   endfunction

   // signed magnitude back to the data range
   function automatic longint signed_from_mag(bit neg, logic [127:0] m);
      logic [127:0] lim;
      lim = neg ? 128'd2147483648 : 128'd2147483647;
      if (m > lim) begin
         sat_seen = 1'b1;
         m = lim;
      end
      return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   function automatic longint mul_q(longint a, longint b);
      logic [127:0] ua, ub, p;
      ua = a < 0 ? 128'(-a) : 128'(a);
      ub = b < 0 ? 128'(-b) : 128'(b);
      p  = ua * ub + (128'd1 << (FRAC - 1));   // round half away from zero
      return signed_from_mag((a < 0) != (b < 0), p >> FRAC);
   endfunction

   function automatic longint div_q(longint a, longint s);
      logic [127:0] ua, us;
      ua = a < 0 ? 128'(-a) : 128'(a);
      us = s < 0 ? 128'(-s) : 128'(s);
      return signed_from_mag((a < 0) != (s < 0), (ua << FRAC) / us);
   endfunction

   function automatic longint add_q(longint a, longint b);
      return clamp_w(a + b);
   endfunction

   function automatic longint sub_q(longint a, longint b);
      return clamp_w(a - b);
   endfunction

   function automatic void reset_tracker_model();
      dt_cfg   = 16777;
      rvar_cfg = 48989;
      qvar_cfg = 16777;
      pos_est  = 1342177;
      vel_est  = 0;
      cov[0]   = 100 * (64'sd1 << FRAC);
      cov[1]   = 0;
      cov[2]   = 0;
      cov[3]   = cov[0];
   endfunction

   // one predict/correct update; returns the selected estimate word
   function automatic estimate_word_type track_update(logic [31:0] z_raw, bit sel_vel);
      longint dt, r, q, z, q00, q01, p00, p01, p10, p11, s, k0, k1, y, t, x0, x1;
      estimate_word_type w;
      sat_seen = 1'b0;
      dt  = clamp_w(longint'(dt_cfg));
      r   = clamp_w(longint'(rvar_cfg));
      q   = clamp_w(longint'(qvar_cfg));
      z   = longint'(signed'(z_raw));
      q00 = mul_q(mul_q(dt, dt), q);
      q01 = mul_q(dt, q);
      x0  = add_q(pos_est, mul_q(dt, vel_est));
      x1  = vel_est;
      p01 = add_q(cov[1], mul_q(dt, cov[3]));
      p10 = add_q(cov[2], mul_q(dt, cov[3]));
      p00 = add_q(add_q(cov[0], mul_q(dt, cov[2])), mul_q(dt, p01));
      p11 = cov[3];
      p00 = add_q(p00, q00);
      p01 = add_q(p01, q01);
      p10 = add_q(p10, q01);
      p11 = add_q(p11, q);
      s   = add_q(p00, r);
      if (s == 0) begin
         // zero innovation variance: gains forced to zero
         sat_seen = 1'b1;
         k0 = 0;
         k1 = 0;
      end else begin
         k0 = div_q(p00, s);
         k1 = div_q(p10, s);
      end
      y  = sub_q(z, x0);
      x0 = add_q(x0, mul_q(k0, y));
      x1 = add_q(x1, mul_q(k1, y));
      t  = sub_q(64'sd1 << FRAC, k0);
      cov[0]  = mul_q(t, p00);
      cov[1]  = mul_q(t, p01);
      cov[2]  = sub_q(p10, mul_q(k1, p00));
      cov[3]  = sub_q(p11, mul_q(k1, p01));
      pos_est = x0;
      vel_est = x1;
      w.estimate  = sel_vel ? x1[31:0] : x0[31:0];
      w.saturated = sat_seen;
      return w;
   endfunction

   // ---------------- bus helpers ----------------
   task automatic idle_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   // valid stays high after a word is taken; a gap or wait_drained drops it,
   // the block is busy far longer than any gap so nothing is taken twice
   task automatic send_measurement(logic [31:0] z, bit sel_vel, int gap_max);
      int gap;
      gap = $urandom_range(gap_max, 0);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         idle_cycles(gap);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= z;
      req_tuser  <= sel_vel;
      do @(posedge clock); while (!req_tready);
      expected_estimates.push_back(track_update(z, sel_vel));
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         kcv_pkg::CSR_TIME_STEP: dt_cfg   = value[30:0];
         kcv_pkg::CSR_MEAS_VAR:  rvar_cfg = value[30:0];
         kcv_pkg::CSR_PROC_VAR:  qvar_cfg = value[30:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // drain every pending estimate, then let the block settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_estimates.size() != 0) @(posedge clock);
      idle_cycles(200);
   endtask

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_estimates.size() == 0) begin
            $error("unexpected estimate word %h", rsp_tdata);
            failed = 1'b1;
         end else begin
            estimate_word_type e;
            e = expected_estimates.pop_front();
            if (rsp_tdata !== e.estimate) begin
               $error("estimate: expected %h, actual %h", e.estimate, rsp_tdata);
               failed = 1'b1;
            end
            if (rsp_tuser[0] !== e.saturated) begin
               $error("saturated: expected %b, actual %b", e.saturated, rsp_tuser[0]);
               failed = 1'b1;
            end
         end
      end
   end

   // result-side stalls: a fresh draw after every word, zero bound means no stall
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         stall = rsp_idle_max == 0 ? 0 : $urandom_range(rsp_idle_max, 0);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            idle_cycles(stall);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // ---------------- tests ----------------
   // field extremes and both selections at reset settings
   task automatic test_field_extremes();
      send_measurement(32'h0000_0000, 1'b0, 0);
      send_measurement(32'h7FFF_FFFF, 1'b0, 0);
      send_measurement(32'h8000_0000, 1'b1, 0);
      send_measurement(32'h0100_0000, 1'b1, 3);
      send_measurement(32'hFFFF_FFFF, 1'b0, 3);
      send_measurement(32'h0147_AE14, 1'b1, 0);
      wait_drained();
   endtask

   // zero innovation variance: all noise terms zero with a collapsed covariance
   task automatic test_zero_variance();
      write_csr(kcv_pkg::CSR_TIME_STEP, 32'd0);
      write_csr(kcv_pkg::CSR_MEAS_VAR, 32'd0);
      write_csr(kcv_pkg::CSR_PROC_VAR, 32'd0);
      repeat (6) send_measurement(32'h0000_0000, 1'b0, 2);
      send_measurement(32'h0100_0000, 1'b1, 0);
      wait_drained();
   endtask

   // largest register values drive saturation everywhere
   task automatic test_saturation();
      write_csr(kcv_pkg::CSR_TIME_STEP, 32'h7FFF_FFFF);
      write_csr(kcv_pkg::CSR_MEAS_VAR, 32'hFFFF_FFFF);
      write_csr(kcv_pkg::CSR_PROC_VAR, 32'h7FFF_FFFF);
      write_csr(2'd3, 32'h0000_0001);   // unmapped register, ignored
      send_measurement(32'h7FFF_FFFF, 1'b0, 0);
      send_measurement(32'h8000_0000, 1'b1, 0);
      send_measurement(32'h1234_5678, 1'b0, 0);
      wait_drained();
   endtask

   // random measurement streams over several register settings
   task automatic test_random_tracking();
      logic [31:0] z;
      for (int phase = 0; phase < 6; phase++) begin
         reset_cov_free_phase(phase);
         for (int n = 0; n < 80; n++) begin
            case ($urandom_range(3, 0))
               0: z = $urandom;                                       // noise
               1: z = 32'($urandom_range(2 ** 26, 0)) - 32'(2 ** 25); // near zero
               default: z = 32'(n) << 20 ^ ($urandom & 32'h000F_FFFF); // ramp
            endcase
            rsp_idle_max = (phase == 2) ? 0 : 13;
            send_measurement(z, 1'($urandom_range(1, 0)), (phase == 3) ? 0 : 13);
         end
         wait_drained();
      end
   endtask

   // register setting for a random phase: reset values, small, large and random
   task automatic reset_cov_free_phase(int phase);
      case (phase)
         0: begin
            write_csr(kcv_pkg::CSR_TIME_STEP, 32'd16777);
            write_csr(kcv_pkg::CSR_MEAS_VAR, 32'd48989);
            write_csr(kcv_pkg::CSR_PROC_VAR, 32'd16777);
         end
         1: begin
            write_csr(kcv_pkg::CSR_TIME_STEP, 32'd1);
            write_csr(kcv_pkg::CSR_MEAS_VAR, 32'd1);
            write_csr(kcv_pkg::CSR_PROC_VAR, 32'd0);
         end
         2: begin
            write_csr(kcv_pkg::CSR_TIME_STEP, 32'h0100_0000);
            write_csr(kcv_pkg::CSR_MEAS_VAR, 32'h0100_0000);
            write_csr(kcv_pkg::CSR_PROC_VAR, 32'h0010_0000);
         end
         default: begin
            write_csr(kcv_pkg::CSR_TIME_STEP, $urandom_range(32'h0200_0000, 0));
            write_csr(kcv_pkg::CSR_MEAS_VAR, $urandom);
            write_csr(kcv_pkg::CSR_PROC_VAR, $urandom_range(32'h0100_0000, 0));
         end
      endcase
   endtask

   initial begin
      failed       = 1'b0;
      rsp_idle_max = 13;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      reset_tracker_model();
      idle_cycles(2);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_zero_variance();
      test_saturation();
      test_random_tracking();

      wait_drained();
      if (!failed) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> kalman_cv_position_tracker_unit.f
hdl/kcv_pkg.sv
hdl/kcv_ctrl.sv
hdl/kcv_datapath.sv
hdl/kalman_cv_position_tracker_unit.sv
tb/kalman_cv_position_tracker_unit_tb.sv
